// ===== rtl/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the shift-reduce recognizer.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int SYM_W    = 7;
   localparam int PROD_W   = 52;
   localparam int NUM_PROD = 8;
   localparam int RHS_SLOTS = 6;
   localparam int CSR_IDX_W = 3;
   localparam logic [SYM_W-1:0] BOTTOM_MARK = 7'd36;

   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_NO_MATCH = 3'd2;
   localparam logic [2:0] ST_CONFLICT = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_LIMIT    = 3'd5;
   localparam logic [2:0] ST_DISCARD  = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_CHECK,
      S_LOAD,
      S_SCAN,
      S_REDUCE,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;      // latch request
      logic shift;      // push input symbol
      logic load;       // load suffix window from stack
      logic load_step;  // window fill step
      logic scan_step;  // try next suffix length
      logic reduce;     // apply matched production
      logic finish;     // latch status, build response
      logic [2:0] status;
      logic clear_out;  // response taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic failed;
      logic has;
      logic last;
      logic full;
      logic top_is_start;
      logic load_done;
      logic scan_done;   // no more lengths
      logic hit;         // one or more matches at current length
      logic conflict;
      logic limit;       // reduction count at max
      logic out_valid;
   } sts_type;

endpackage

// ===== rtl/srr_datapath.sv =====
// ----------------------------------------------------------------------------
// srr_datapath
// Symbol stack memory, suffix window, production matcher, response register.
// ----------------------------------------------------------------------------
module srr_datapath #(
   parameter int STACK_DEPTH     = 64,
   parameter int MAX_PRODUCTIONS = 8,
   parameter int MAX_RHS         = 6,
   parameter int MAX_REDUCTIONS  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic [srr_pkg::SYM_W-1:0] req_symbol,
   input  logic req_has_symbol,
   input  logic req_is_last,
   input  logic csr_write,
   input  logic [srr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srr_pkg::PROD_W-1:0] csr_data,
   input  srr_pkg::cmd_type cmd,
   output srr_pkg::sts_type sts,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_depth_now,
   output logic [5:0] rsp_reductions_done
);
   import srr_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int HW = $clog2(STACK_DEPTH + 1);
   localparam int RW = $clog2(MAX_REDUCTIONS + 1);
   localparam int LW = 3;

   logic [PROD_W-1:0] prod_ff [NUM_PROD];
   logic [SYM_W-1:0]  mem [STACK_DEPTH];
   logic [SYM_W-1:0]  rd_ff;
   logic [SYM_W-1:0]  win_ff [RHS_SLOTS];   // win_ff[0] = top
   logic [HW-1:0] height_ff, height_in;
   logic [RW-1:0] red_ff;
   logic [LW-1:0] fill_ff, k_ff;
   logic [SYM_W-1:0] sym_ff;
   logic has_ff, last_ff, failed_ff, pend_ff;
   logic out_valid_ff;
   logic [2:0] st_ff;
   logic [6:0] dep_ff;
   logic [5:0] rd_cnt_ff;
   logic [SYM_W-1:0] lhs_sel_ff;
   logic [LW-1:0] len_sel_ff;

   logic [LW-1:0] fill_lim;
   logic [NUM_PROD-1:0] match;
   logic [SYM_W-1:0] top;
   logic mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [SYM_W-1:0] mem_wd;
   logic [HW-1:0] kh;
   logic [SYM_W-1:0] hit_lhs;
   logic hit_one, hit_many;

   always_ff @(posedge clock) begin
      if (csr_write && (int'(csr_index) < NUM_PROD))
         prod_ff[csr_index] <= csr_data;
      if (reset) begin
         for (int i = 0; i < NUM_PROD; i++) prod_ff[i] <= '0;
      end
   end

   // window fill count: min(height, MAX_RHS)
   always_comb begin
      if (height_ff >= HW'(MAX_RHS)) fill_lim = LW'(MAX_RHS);
      else fill_lim = LW'(height_ff);
   end

   assign top = (height_ff == '0) ? BOTTOM_MARK : win_ff[0];
   assign kh  = HW'(k_ff);

   // matcher for current suffix length k_ff
   always_comb begin
      hit_lhs = '0;
      hit_one = 1'b0;
      hit_many = 1'b0;
      for (int p = 0; p < NUM_PROD; p++) begin
         match[p] = (p < MAX_PRODUCTIONS) && (prod_ff[p][9:7] == k_ff) &&
                    (k_ff != '0) && (int'(k_ff) <= MAX_RHS);
         for (int i = 0; i < RHS_SLOTS; i++) begin
            if (i < int'(k_ff) &&
                prod_ff[p][10+7*i +: 7] != win_ff[int'(k_ff)-1-i])
               match[p] = 1'b0;
         end
      end
      for (int p = NUM_PROD - 1; p >= 0; p--) begin
         if (match[p]) hit_lhs = prod_ff[p][6:0];
      end
      hit_one  = (match != '0);
      hit_many = (match & (match - 1'b1)) != '0;
   end

   // memory port selects
   always_comb begin
      mem_we = 1'b0;
      mem_wa = AW'(height_ff);
      mem_wd = sym_ff;
      height_in = height_ff;
      if (cmd.shift) begin
         mem_we = 1'b1;
         height_in = height_ff + 1'b1;
      end else if (cmd.reduce) begin
         mem_we = 1'b1;
         mem_wa = AW'(height_ff - HW'(len_sel_ff));
         mem_wd = lhs_sel_ff;
         height_in = height_ff - HW'(len_sel_ff) + 1'b1;
      end else if (cmd.finish && cmd.status != ST_PENDING &&
                   cmd.status != ST_DISCARD) begin
         height_in = '0;
      end
      mem_ra = AW'(height_ff - HW'(fill_lim) + HW'(fill_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
         failed_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         height_ff <= height_in;
         lhs_sel_ff <= hit_lhs;
         len_sel_ff <= k_ff;
         if (mem_we) win_ff[0] <= mem_wd;
         if (cmd.start) begin
            sym_ff  <= req_symbol;
            has_ff  <= req_has_symbol;
            last_ff <= req_is_last;
            red_ff  <= '0;
         end
         if (cmd.load) begin
            fill_ff <= '0;
            k_ff    <= '0;
            pend_ff <= 1'b0;
         end
         if (cmd.load_step) begin
            // read issued at fill_ff last cycle lands now
            if (pend_ff) begin
               for (int i = RHS_SLOTS - 1; i > 0; i--) win_ff[i] <= win_ff[i-1];
               win_ff[0] <= rd_ff;
            end
            if (fill_ff != fill_lim) fill_ff <= fill_ff + 1'b1;
            pend_ff <= (fill_ff != fill_lim);
         end
         if (cmd.scan_step) k_ff <= k_ff + 1'b1;
         if (cmd.reduce) red_ff <= red_ff + 1'b1;
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
            st_ff <= cmd.status;
            if (cmd.status == ST_DISCARD) begin
               dep_ff <= '0;
               rd_cnt_ff <= '0;
               if (last_ff) failed_ff <= 1'b0;
            end else begin
               dep_ff <= 7'(height_ff);
               rd_cnt_ff <= 6'(red_ff);
               if (cmd.status != ST_PENDING) begin
                  if (!last_ff) failed_ff <= 1'b1;
               end
            end
         end
         if (cmd.clear_out) out_valid_ff <= 1'b0;
      end
   end

   // window reads go deepest-first and shift in at win_ff[0], so the top lands
   // in win_ff[0]
   assign sts.failed       = failed_ff;
   assign sts.has          = has_ff;
   assign sts.last         = last_ff;
   assign sts.full         = (height_ff >= HW'(STACK_DEPTH));
   assign sts.top_is_start = (top == prod_ff[0][6:0]);
   assign sts.load_done    = (fill_ff == fill_lim) && !pend_ff;
   assign sts.scan_done    = (k_ff >= fill_lim);
   assign sts.hit          = hit_one && (k_ff != '0) && (kh <= height_ff);
   assign sts.conflict     = hit_many && (k_ff != '0) && (kh <= height_ff);
   assign sts.limit        = (red_ff >= RW'(MAX_REDUCTIONS));
   assign sts.out_valid    = out_valid_ff;

   assign rsp_status          = st_ff;
   assign rsp_depth_now       = dep_ff;
   assign rsp_reductions_done = rd_cnt_ff;

endmodule

// ===== rtl/srr_control.sv =====
// ----------------------------------------------------------------------------
// srr_control
// Sequencer: shift, window load, suffix scan, reduce, respond.
// ----------------------------------------------------------------------------
module srr_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  srr_pkg::sts_type sts,
   output srr_pkg::cmd_type cmd
);
   import srr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid = sts.out_valid;
      req_ready = (state_ff == S_IDLE) && !sts.out_valid;
      cmd.clear_out = sts.out_valid && rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.start = 1'b1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (sts.failed) begin
               cmd.finish = 1'b1;
               cmd.status = ST_DISCARD;
               state_in = S_IDLE;
            end else if (sts.has && sts.full) begin
               cmd.finish = 1'b1;
               cmd.status = ST_OVERFLOW;
               state_in = S_IDLE;
            end else begin
               cmd.shift = sts.has;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.last && sts.top_is_start) begin
               cmd.finish = 1'b1;
               cmd.status = ST_ACCEPTED;
               state_in = S_IDLE;
            end else begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.load_done) begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN;
            end else begin
               cmd.load_step = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.conflict) begin
               cmd.finish = 1'b1;
               cmd.status = ST_CONFLICT;
               state_in = S_IDLE;
            end else if (sts.hit) begin
               if (sts.limit) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_LIMIT;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_REDUCE;
               end
            end else if (sts.scan_done) begin
               cmd.finish = 1'b1;
               cmd.status = sts.last ? ST_NO_MATCH : ST_PENDING;
               state_in = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in = S_CHECK;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/shift_reduce_recognizer.sv =====
// ----------------------------------------------------------------------------
// shift_reduce_recognizer
// Greedy shift-reduce recognizer over up to eight configured productions.
//
//   channel  ports                              dir
//   req      req_valid/ready, symbol/has/last   in
//   rsp      rsp_valid/ready, status/depth/red  out
//   csr      csr_write, csr_index, csr_data     in
//
// Per item: a shift, then per reduction pass a window reload through the single
// stack read port, deepest entry first, a suffix scan and a reduce.
// One item in flight; the next beat is taken once the response is taken.
// Reset empties the stack and clears the error hold; no clearing pass.
// ----------------------------------------------------------------------------
module shift_reduce_recognizer #(
   parameter int STACK_DEPTH     = 64,
   parameter int MAX_PRODUCTIONS = 8,
   parameter int MAX_RHS         = 6,
   parameter int MAX_REDUCTIONS  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [srr_pkg::SYM_W-1:0] req_symbol,
   input  logic req_has_symbol,
   input  logic req_is_last,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_depth_now,
   output logic [5:0] rsp_reductions_done,
   input  logic csr_write,
   input  logic [srr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srr_pkg::PROD_W-1:0] csr_data
);
   import srr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   srr_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   srr_datapath #(
      .STACK_DEPTH(STACK_DEPTH), .MAX_PRODUCTIONS(MAX_PRODUCTIONS),
      .MAX_RHS(MAX_RHS), .MAX_REDUCTIONS(MAX_REDUCTIONS)
   ) u_dp (
      .clock, .reset, .req_symbol, .req_has_symbol, .req_is_last,
      .csr_write, .csr_index, .csr_data, .cmd, .sts,
      .rsp_status, .rsp_depth_now, .rsp_reductions_done
   );

endmodule
